FILE: rtl/core/ostc_pkg.sv
// shared widths, command codes, register offsets and the request type of the timer core
package ostc_pkg;

    // field widths
    localparam int unsigned CMD_W   = 2;
    localparam int unsigned ADDR_W  = 12;
    localparam int unsigned DATA_W  = 32;
    localparam int unsigned COUNT_W = 64;

    // command codes
    localparam logic [CMD_W-1:0] CMD_TICK  = 2'd0;
    localparam logic [CMD_W-1:0] CMD_READ  = 2'd1;
    localparam logic [CMD_W-1:0] CMD_WRITE = 2'd2;

    // register byte offsets
    localparam logic [ADDR_W-1:0] REG_ENABLE  = 12'h000;
    localparam logic [ADDR_W-1:0] REG_DISABLE = 12'h004;
    localparam logic [ADDR_W-1:0] REG_CNT_HI  = 12'h008;
    localparam logic [ADDR_W-1:0] REG_CNT_LO  = 12'h00C;
    localparam logic [ADDR_W-1:0] REG_CONTROL = 12'h010;
    localparam logic [ADDR_W-1:0] REG_COMPARE = 12'h014;
    localparam logic [ADDR_W-1:0] REG_FLAG    = 12'h018;
    localparam logic [ADDR_W-1:0] REG_MASK    = 12'h01C;

    // one request as held in the input register
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] write_data;
    } t_req;

endpackage

FILE: rtl/core/ostc_if.sv
// request and response channel interfaces of the timer core
interface ostc_req_if;
    logic                          valid;
    logic                          ready;
    logic [ostc_pkg::CMD_W-1:0]    command;
    logic [ostc_pkg::ADDR_W-1:0]   address;
    logic [ostc_pkg::DATA_W-1:0]   write_data;

    modport source (output valid, output command, output address, output write_data,
                    input ready);
    modport sink   (input valid, input command, input address, input write_data,
                    output ready);
endinterface

interface ostc_rsp_if;
    logic                          valid;
    logic                          ready;
    logic [ostc_pkg::DATA_W-1:0]   read_data;
    logic                          irq;

    modport source (output valid, output read_data, output irq, input ready);
    modport sink   (input valid, input read_data, input irq, output ready);
endinterface

FILE: rtl/core/os_timer_compare_irq_core.sv
// top level of the timer core: input register, register file and result register
//
// Tick-driven 64-bit timer with a compare interrupt behind a small register window.
// Request channel i_req carries command (tick, register read, register write),
// a 12-bit byte address and 32-bit write data. Response channel o_rsp returns one
// response per request: read_data (zero for ticks, writes and unknown offsets) and
// irq, the interrupt level after that request.
// An accepted request waits in the input register and executes as it moves into
// the result register, from which its response is offered on o_rsp.
// Throughput: one request per cycle unless the receiver stalls; the counter
// increment and 64-bit compare are combinational between the two registers.
// Reset (synchronous, active low) clears the timer disabled, counter, control,
// compare, flag, mask and irq to zero, and empties both pipeline registers.
// When the receiver stalls, the response holds in the result register, one more
// request waits in the input register, and i_req.ready drops until o_rsp.ready
// returns; no request is lost or executed twice.
module os_timer_compare_irq_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    ostc_req_if.sink    i_req,
    ostc_rsp_if.source  o_rsp
);

    logic                        r_s1_vld;
    ostc_pkg::t_req              r_s1_req;
    logic                        r_out_vld;
    logic [ostc_pkg::DATA_W-1:0] r_out_rd;
    logic                        r_out_irq;
    logic                        adv;
    logic [ostc_pkg::DATA_W-1:0] exec_rd;
    logic                        exec_irq;

    // a request executes when the result register is free or being emptied
    assign adv         = r_s1_vld && (!r_out_vld || o_rsp.ready);
    assign i_req.ready = !r_s1_vld || adv;

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
        end else if (i_req.ready) begin
            r_s1_vld <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.ready && i_req.valid) begin
            r_s1_req.command    <= i_req.command;
            r_s1_req.address    <= i_req.address;
            r_s1_req.write_data <= i_req.write_data;
        end
    end

    ostc_regs u_regs (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_exec      (adv),
        .i_req       (r_s1_req),
        .o_read_data (exec_rd),
        .o_irq       (exec_irq)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (adv) begin
            r_out_vld <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_out_rd  <= exec_rd;
            r_out_irq <= exec_irq;
        end
    end

    assign o_rsp.valid     = r_out_vld;
    assign o_rsp.read_data = r_out_rd;
    assign o_rsp.irq       = r_out_irq;

endmodule

FILE: rtl/core/ostc_regs.sv
// register file, 64-bit counter and compare logic of the timer core
module ostc_regs (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_exec,
    input  ostc_pkg::t_req              i_req,
    output logic [ostc_pkg::DATA_W-1:0] o_read_data,
    output logic                        o_irq
);

    logic                          r_run,     n_run;
    logic [ostc_pkg::COUNT_W-1:0]  r_count,   n_count;
    logic [ostc_pkg::DATA_W-1:0]   r_control, n_control;
    logic [ostc_pkg::DATA_W-1:0]   r_compare, n_compare;
    logic                          r_flag,    n_flag;
    logic [ostc_pkg::DATA_W-1:0]   r_mask,    n_mask;
    logic                          r_irq,     n_irq;
    logic [ostc_pkg::DATA_W-1:0]   rd;

    // next state and read data for the request in the input register
    always_comb begin
        n_run     = r_run;
        n_count   = r_count;
        n_control = r_control;
        n_compare = r_compare;
        n_flag    = r_flag;
        n_mask    = r_mask;
        n_irq     = r_irq;
        rd        = '0;
        case (i_req.command)
            ostc_pkg::CMD_TICK: begin
                if (r_run) begin
                    n_count = r_count + 64'd1;
                    // compare at full width against the zero-extended compare value
                    if ((n_count[63:32] != 32'd0) || (n_count[31:0] >= r_compare)) begin
                        n_flag = 1'b1;
                        if (!r_mask[0]) begin
                            n_irq = 1'b1;
                        end
                    end
                end
            end
            ostc_pkg::CMD_READ: begin
                case (i_req.address)
                    ostc_pkg::REG_ENABLE:  rd = {31'd0, r_run};
                    ostc_pkg::REG_CNT_HI:  rd = r_count[63:32];
                    ostc_pkg::REG_CNT_LO:  rd = r_count[31:0];
                    ostc_pkg::REG_CONTROL: rd = r_control;
                    ostc_pkg::REG_COMPARE: rd = r_compare;
                    ostc_pkg::REG_FLAG:    rd = {31'd0, r_flag};
                    ostc_pkg::REG_MASK:    rd = r_mask;
                    default:               rd = '0;
                endcase
            end
            ostc_pkg::CMD_WRITE: begin
                case (i_req.address)
                    ostc_pkg::REG_ENABLE:  n_run = i_req.write_data[0];
                    ostc_pkg::REG_DISABLE: begin
                        if (i_req.write_data[0]) begin
                            n_run = 1'b0;
                        end
                    end
                    ostc_pkg::REG_CONTROL: n_control = i_req.write_data;
                    ostc_pkg::REG_COMPARE: n_compare = i_req.write_data;
                    ostc_pkg::REG_FLAG: begin
                        // write one to clear; a clear flag always drops the line
                        if (i_req.write_data[0]) begin
                            n_flag = 1'b0;
                        end
                        if (!n_flag) begin
                            n_irq = 1'b0;
                        end
                    end
                    ostc_pkg::REG_MASK:    n_mask = i_req.write_data;
                    default:               n_run = r_run;
                endcase
            end
            default: rd = '0;
        endcase
    end

    // state update when the request moves to the result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run     <= 1'b0;
            r_count   <= '0;
            r_control <= '0;
            r_compare <= '0;
            r_flag    <= 1'b0;
            r_mask    <= '0;
            r_irq     <= 1'b0;
        end else if (i_exec) begin
            r_run     <= n_run;
            r_count   <= n_count;
            r_control <= n_control;
            r_compare <= n_compare;
            r_flag    <= n_flag;
            r_mask    <= n_mask;
            r_irq     <= n_irq;
        end
    end

    assign o_read_data = rd;
    assign o_irq       = n_irq;

endmodule

FILE: test/testbench.sv
// self-checking testbench of the timer core: request driver, response sink and predictor
`timescale 1ns / 1ps

module testbench;
    import ostc_pkg::*;

    // command code with no operation behind it
    localparam logic [CMD_W-1:0] CMD_NOP = 2'd3;
    localparam int unsigned QUIET_LIMIT = 2000;
    localparam int unsigned LONG_HOLD   = 400;
    localparam int unsigned PHASE_ITEMS = 680;

    // predicted timer registers and the responses still owed by the core
    class timer_scoreboard;
        typedef struct packed {
            logic [DATA_W-1:0] read_data;
            logic              irq;
        } t_rsp;

        bit                run_enable;
        bit [COUNT_W-1:0]  tick_count;
        bit [DATA_W-1:0]   control_word;
        bit [DATA_W-1:0]   compare_value;
        bit                match_flag;
        bit [DATA_W-1:0]   mask_word;
        bit                irq_level;
        t_rsp              owed_rsp[$];
        int unsigned       fail_count;
        int unsigned       n_tick, n_read, n_write, n_other, n_irq_rise, n_rsp;

        // apply one accepted request and queue the response it must produce
        function void note_request(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                   logic [DATA_W-1:0] data);
            t_rsp rsp;
            bit   irq_was;
            irq_was        = irq_level;
            rsp.read_data  = '0;
            case (cmd)
                CMD_TICK: begin
                    n_tick++;
                    if (run_enable) begin
                        tick_count = tick_count + 1;
                        if (tick_count >= {32'd0, compare_value}) begin
                            match_flag = 1'b1;
                            if (!mask_word[0]) irq_level = 1'b1;
                        end
                    end
                end
                CMD_READ: begin
                    n_read++;
                    case (addr)
                        REG_ENABLE:  rsp.read_data = {31'd0, run_enable};
                        REG_CNT_HI:  rsp.read_data = tick_count[63:32];
                        REG_CNT_LO:  rsp.read_data = tick_count[31:0];
                        REG_CONTROL: rsp.read_data = control_word;
                        REG_COMPARE: rsp.read_data = compare_value;
                        REG_FLAG:    rsp.read_data = {31'd0, match_flag};
                        REG_MASK:    rsp.read_data = mask_word;
                        default:     rsp.read_data = '0;
                    endcase
                end
                CMD_WRITE: begin
                    n_write++;
                    case (addr)
                        REG_ENABLE:  run_enable = data[0];
                        REG_DISABLE: if (data[0]) run_enable = 1'b0;
                        REG_CONTROL: control_word = data;
                        REG_COMPARE: compare_value = data;
                        REG_FLAG: begin
                            if (data[0]) match_flag = 1'b0;
                            if (!match_flag) irq_level = 1'b0;
                        end
                        REG_MASK:    mask_word = data;
                        default:     ;
                    endcase
                end
                default: n_other++;
            endcase
            if (irq_level && !irq_was) n_irq_rise++;
            rsp.irq = irq_level;
            owed_rsp.push_back(rsp);
        endfunction

        // compare one accepted response with the oldest owed one
        function void check_response(logic [DATA_W-1:0] rd, logic irq);
            t_rsp want;
            n_rsp++;
            if (owed_rsp.size() == 0) begin
                fail_count++;
                $display("%0t: response with no request pending: read_data %h irq %b",
                         $time, rd, irq);
                return;
            end
            want = owed_rsp.pop_front();
            if (rd !== want.read_data) begin
                fail_count++;
                $display("%0t: read_data mismatch: expected %h actual %h",
                         $time, want.read_data, rd);
            end
            if (irq !== want.irq) begin
                fail_count++;
                $display("%0t: irq mismatch: expected %b actual %b", $time, want.irq, irq);
            end
        endfunction
    endclass

    logic i_clk;
    logic i_rst_n;
    ostc_req_if req_ch ();
    ostc_rsp_if rsp_ch ();

    timer_scoreboard sb;
    int unsigned     send_idle_pct;
    int unsigned     recv_idle_pct;
    int unsigned     rsp_hold_left;
    int unsigned     quiet_cycles;

    os_timer_compare_irq_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // clock
    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // response sink: random stalls plus one long hold-off
    initial begin
        rsp_ch.ready = 1'b0;
        @(negedge i_clk);
        while (!i_rst_n) @(negedge i_clk);
        forever begin
            if (rsp_hold_left != 0) begin
                rsp_ch.ready = 1'b0;
                rsp_hold_left--;
            end else begin
                rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
            end
            @(negedge i_clk);
        end
    end

    // monitor on both channels
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rsp_ch.valid && rsp_ch.ready)
                sb.check_response(rsp_ch.read_data, rsp_ch.irq);
            if (req_ch.valid && req_ch.ready)
                sb.note_request(req_ch.command, req_ch.address, req_ch.write_data);
            if ((rsp_ch.valid && rsp_ch.ready) || (req_ch.valid && req_ch.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    // watchdog on cycles with no handshake
    initial begin
        quiet_cycles = 0;
        while (quiet_cycles < QUIET_LIMIT) @(posedge i_clk);
        $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
        $display("CHECKS FAILED");
        $finish;
    end

    // offer one request, called and returning at a falling edge
    task automatic push_request(logic [CMD_W-1:0] cmd, logic [ADDR_W-1:0] addr,
                                logic [DATA_W-1:0] data);
        while ($urandom_range(99) < send_idle_pct) begin
            req_ch.valid = 1'b0;
            @(negedge i_clk);
        end
        req_ch.valid      = 1'b1;
        req_ch.command    = cmd;
        req_ch.address    = addr;
        req_ch.write_data = data;
        do @(posedge i_clk); while (!req_ch.ready);
        @(negedge i_clk);
    endtask

    // random request, mostly register traffic that drives the compare logic
    task automatic push_random_request();
        logic [ADDR_W-1:0] reg_addr;
        logic [ADDR_W-1:0] addr;
        logic [DATA_W-1:0] data;
        int unsigned       pick;
        int unsigned       sel;
        reg_addr = ADDR_W'($urandom_range(7) * 4);
        data     = $urandom;
        pick     = $urandom_range(99);
        sel      = $urandom_range(99);
        if (pick < 40) begin
            push_request(CMD_TICK, ADDR_W'($urandom), data);
        end else if (pick < 65) begin
            addr = (sel < 90) ? reg_addr : ADDR_W'($urandom);
            push_request(CMD_READ, addr, data);
        end else if (pick < 93) begin
            addr = (sel < 92) ? reg_addr : ADDR_W'($urandom);
            // compare values near the running count so matches come often
            if (addr == REG_COMPARE) begin
                if (sel < 50)
                    data = sb.tick_count[31:0] + DATA_W'($urandom_range(12));
                else if (sel < 70)
                    data = sb.tick_count[31:0] - DATA_W'($urandom_range(4));
                else if (sel < 85)
                    data = '0;
            end
            // keep the timer running most of the time
            if (addr == REG_ENABLE && sel < 75) data[0] = 1'b1;
            if (addr == REG_DISABLE && sel < 60) data[0] = 1'b0;
            push_request(CMD_WRITE, addr, data);
        end else begin
            push_request(CMD_NOP, ADDR_W'($urandom), data);
        end
    endtask

    // main sequence
    initial begin
        sb                = new;
        i_rst_n           = 1'b0;
        req_ch.valid      = 1'b0;
        req_ch.command    = CMD_TICK;
        req_ch.address    = '0;
        req_ch.write_data = '0;
        send_idle_pct     = 32;
        recv_idle_pct     = 82;
        rsp_hold_left     = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed: disabled tick, compare match, mask, flag clearing, odd addresses
        push_request(CMD_TICK,  12'h000, 32'hFFFF_FFFF);
        push_request(CMD_READ,  REG_CNT_LO, 32'h0);
        push_request(CMD_WRITE, REG_COMPARE, 32'd3);
        push_request(CMD_WRITE, REG_ENABLE, 32'hFFFF_FFFF);
        repeat (3) push_request(CMD_TICK, 12'hFFF, 32'h0);
        push_request(CMD_READ,  REG_FLAG, 32'h0);
        push_request(CMD_WRITE, REG_MASK, 32'hFFFF_FFFF);
        push_request(CMD_WRITE, REG_FLAG, 32'hFFFF_FFFE);
        push_request(CMD_WRITE, REG_FLAG, 32'h0000_0001);
        push_request(CMD_TICK,  12'h000, 32'h0);
        push_request(CMD_WRITE, REG_MASK, 32'h0);
        push_request(CMD_WRITE, REG_CONTROL, 32'hFFFF_FFFF);
        push_request(CMD_READ,  REG_CONTROL, 32'h0);
        push_request(CMD_WRITE, REG_COMPARE, 32'hFFFF_FFFF);
        push_request(CMD_READ,  REG_COMPARE, 32'h0);
        push_request(CMD_WRITE, REG_CNT_LO, 32'hFFFF_FFFF);
        push_request(CMD_READ,  REG_CNT_HI, 32'h0);
        push_request(CMD_READ,  12'hFFF, 32'h0);
        push_request(CMD_READ,  12'h015, 32'h0);
        push_request(CMD_WRITE, 12'hFFF, 32'hFFFF_FFFF);
        push_request(CMD_NOP,   REG_FLAG, 32'hFFFF_FFFF);
        push_request(CMD_WRITE, REG_DISABLE, 32'h0);
        push_request(CMD_WRITE, REG_DISABLE, 32'h1);
        push_request(CMD_TICK,  12'h000, 32'h0);
        push_request(CMD_WRITE, REG_ENABLE, 32'h1);

        // random traffic in three idling phases
        for (int phase = 0; phase < 3; phase++) begin
            case (phase)
                0: begin send_idle_pct = 32; recv_idle_pct = 82; end
                1: begin send_idle_pct = 82; recv_idle_pct = 32; end
                default: begin
                    send_idle_pct = 0;
                    recv_idle_pct = 0;
                    // sink holds off while requests keep coming
                    rsp_hold_left = LONG_HOLD;
                end
            endcase
            repeat (PHASE_ITEMS) push_random_request();
        end
        req_ch.valid = 1'b0;

        // drain outstanding responses, then keep watching for stray responses
        while (sb.owed_rsp.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        if (sb.owed_rsp.size() != 0) begin
            sb.fail_count++;
            $display("%0t: %0d responses never arrived", $time, sb.owed_rsp.size());
        end
        $display("run covered %0d ticks, %0d reads, %0d writes and %0d no-op requests",
                 sb.n_tick, sb.n_read, sb.n_write, sb.n_other);
        $display("%0d responses checked, interrupt raised %0d times, final count %0d",
                 sb.n_rsp, sb.n_irq_rise, sb.tick_count);
        if (sb.fail_count == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
